FILE: rtl/adcm_pkg.sv
// Shared types, constants and the exp ROM contents for the AD-census matching cost block.
package adcm_pkg;

	// Sizing of the window and of the exp ROM
	localparam int MAX_WINDOW_ELEMENTS = 63;
	localparam int EXP_TABLE_DEPTH     = 256;
	localparam int EXP_IDX_W           = $clog2(EXP_TABLE_DEPTH);

	// Census counter saturates at the smaller of 3*MAX_WINDOW_ELEMENTS and 255
	localparam int CENSUS_LIMIT =
		(3 * MAX_WINDOW_ELEMENTS > 255) ? 255 : 3 * MAX_WINDOW_ELEMENTS;

	// Field and datapath widths
	localparam int PIX_W      = 8;
	localparam int NUM_CH     = 3;
	localparam int AD_W       = 10;
	localparam int CNT_W      = 8;
	localparam int RECIP_W    = 16;
	localparam int EXP_W      = 15;
	localparam int TOTAL_W    = 15;
	localparam int ARG_SHIFT  = 12;
	localparam int PROD_AD_W  = AD_W + RECIP_W;
	localparam int PROD_CEN_W = CNT_W + RECIP_W;
	localparam int IN_DATA_W  = 2 * NUM_CH * PIX_W;
	localparam int OUT_DATA_W = 40;

	// Configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_RECIP_AD     = 1'b0;
	localparam logic REG_RECIP_CENSUS = 1'b1;
	localparam logic [RECIP_W-1:0] RECIP_AD_RESET     = 16'd2185;
	localparam logic [RECIP_W-1:0] RECIP_CENSUS_RESET = 16'd2185;

	// Command codes carried on tuser
	localparam logic CMD_CENTER = 1'b0;
	localparam logic CMD_WINDOW = 1'b1;

	// Result of one color channel lane
	typedef struct packed {
		logic             mismatch;
		logic [PIX_W-1:0] abs_diff;
	} lane_res_t;

	// Work handed from the merge stage to the cost stage
	typedef struct packed {
		logic [AD_W-1:0]  ad_sum;
		logic [CNT_W-1:0] census_count;
	} cost_req_t;

	// exp(-2^b/16) in Q0.32
	localparam logic [63:0] EXP_POW2_Q32 [12] = '{
		64'd4034748382, 64'd3790295335, 64'd3344923893, 64'd2605029348,
		64'd1580030169, 64'd581260616,  64'd78665070,   64'd1440801,
		64'd483,        64'd0,          64'd0,          64'd0
	};

	typedef logic [EXP_W-1:0] exp_rom_t [EXP_TABLE_DEPTH];

	// Entry i is exp(-i/16) in Q0.14, built from rounded Q0.32 partial products
	function automatic exp_rom_t build_exp_rom();
		exp_rom_t    rom;
		logic [63:0] acc;
		for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
			acc = 64'd1 << 32;
			for (int b = 0; b < 12; b++) begin
				if (i[b]) begin
					acc = (acc * EXP_POW2_Q32[b] + (64'd1 << 31)) >> 32;
				end
			end
			rom[i] = EXP_W'((acc + (64'd1 << 17)) >> 18);
		end
		return rom;
	endfunction

	localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

FILE: rtl/adcm_lane.sv
// One color channel lane: census sign compare and absolute difference.
module adcm_lane import adcm_pkg::*; (
	input  logic [PIX_W-1:0] left_pix,
	input  logic [PIX_W-1:0] right_pix,
	input  logic [PIX_W-1:0] left_ctr,
	input  logic [PIX_W-1:0] right_ctr,
	output lane_res_t        res
);

	// Flag samples that sit strictly on opposite sides of their centers
	always_comb begin
		res.mismatch = ((left_pix < left_ctr) && (right_pix > right_ctr)) ||
			((left_pix > left_ctr) && (right_pix < right_ctr));
		res.abs_diff = (left_pix > right_pix) ? (left_pix - right_pix)
			: (right_pix - left_pix);
	end

endmodule

FILE: rtl/adcm_cost.sv
// Cost stages: reciprocal multiply, exp ROM lookup, combine and output register.
module adcm_cost import adcm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	input  cost_req_t             req,
	output logic                  req_ready,
	input  logic [RECIP_W-1:0]    recip_ad,
	input  logic [RECIP_W-1:0]    recip_census,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata
);

	logic                    v_s2;
	cost_req_t               req_s2;
	logic [PROD_AD_W-1:0]    prod_ad_s2;
	logic [PROD_CEN_W-1:0]   prod_cen_s2;
	logic                    out_valid_q;
	logic [TOTAL_W-1:0]      total_q;
	cost_req_t               out_req_q;
	logic                    adv_out;
	logic [PROD_AD_W-ARG_SHIFT-1:0]  arg_ad;
	logic [PROD_CEN_W-ARG_SHIFT-1:0] arg_cen;
	logic [EXP_IDX_W-1:0]    idx_ad;
	logic [EXP_IDX_W-1:0]    idx_cen;
	logic [EXP_W-1:0]        exp_ad;
	logic [EXP_W-1:0]        exp_cen;
	logic [TOTAL_W:0]        total_raw;
	logic [TOTAL_W-1:0]      total_sat;

	// Advance when the next stage is empty or draining
	assign adv_out   = !out_valid_q || m_tready;
	assign req_ready = !v_s2 || adv_out;

	// Multiply stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (req_ready) begin
			v_s2 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s2      <= req;
			prod_ad_s2  <= PROD_AD_W'(req.ad_sum) * PROD_AD_W'(recip_ad);
			prod_cen_s2 <= PROD_CEN_W'(req.census_count) * PROD_CEN_W'(recip_census);
		end
	end

	// Truncate to Q4.4, clamp to the ROM range, look up and combine
	always_comb begin
		arg_ad  = prod_ad_s2[PROD_AD_W-1:ARG_SHIFT];
		arg_cen = prod_cen_s2[PROD_CEN_W-1:ARG_SHIFT];
		idx_ad  = (arg_ad > (PROD_AD_W-ARG_SHIFT)'(EXP_TABLE_DEPTH - 1))
			? EXP_IDX_W'(EXP_TABLE_DEPTH - 1) : arg_ad[EXP_IDX_W-1:0];
		idx_cen = (arg_cen > (PROD_CEN_W-ARG_SHIFT)'(EXP_TABLE_DEPTH - 1))
			? EXP_IDX_W'(EXP_TABLE_DEPTH - 1) : arg_cen[EXP_IDX_W-1:0];
		exp_ad    = EXP_ROM[idx_ad];
		exp_cen   = EXP_ROM[idx_cen];
		total_raw = (TOTAL_W+1)'(32768) - {1'b0, exp_ad} - {1'b0, exp_cen};
		total_sat = (total_raw > (TOTAL_W+1)'(32767)) ? TOTAL_W'(32767)
			: total_raw[TOTAL_W-1:0];
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_out) begin
			out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && v_s2) begin
			total_q   <= total_sat;
			out_req_q <= req_s2;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(OUT_DATA_W-TOTAL_W-AD_W-CNT_W)'(0), out_req_q.census_count,
		out_req_q.ad_sum, total_q};

endmodule

FILE: rtl/ad_census_matching_cost.sv
// Top level of the AD-census matching cost block: config, channel lanes, merge, cost stages.
//
//  port group | direction | contents
//  s_*        | in        | center load or window pixel pair, one word per cycle while s_tready is high
//  m_*        | out       | total_cost, ad_sum, census_count for each last window word
//  p*         | in/out    | APB registers recip_lambda_ad (0x0), recip_lambda_census (0x4)
//
// One input word per clock while s_tready is high; the three lanes and the merge adder
// update the census count in the cycle a word is accepted.
// After its last window word a result passes the merge register, the multiply
// register and the output register.
// Three results can queue in those registers; s_tready drops only when all hold.
// Reset clears the stored centers, sums and counter and loads the register defaults.
module ad_census_matching_cost import adcm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// left_red, left_green, left_blue, right_red, right_green, right_blue
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// cmd
	input  logic                  s_tuser,
	input  logic                  s_tlast,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// total_cost[14:0], ad_sum[24:15], census_count[32:25], zero fill
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_W-1:0]    paddr,
	input  logic [PDATA_W-1:0]    pwdata,
	output logic [PDATA_W-1:0]    prdata,
	output logic                  pready
);

	logic [RECIP_W-1:0] recip_ad_q;
	logic [RECIP_W-1:0] recip_census_q;
	logic [PIX_W-1:0]   left_ctr_q  [NUM_CH];
	logic [PIX_W-1:0]   right_ctr_q [NUM_CH];
	logic [AD_W-1:0]    ad_sum_q;
	logic [CNT_W-1:0]   census_q;
	logic [PIX_W-1:0]   left_pix  [NUM_CH];
	logic [PIX_W-1:0]   right_pix [NUM_CH];
	lane_res_t          lane_res  [NUM_CH];
	logic [1:0]         mis_n;
	logic [CNT_W:0]     cnt_sum;
	logic [CNT_W-1:0]   cnt_next;
	logic [AD_W-1:0]    ad_next;
	logic               accept;
	logic               cfg_wr;
	logic               v_s1;
	cost_req_t          req_s1;
	logic               cost_ready;

	// Configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recip_ad_q     <= RECIP_AD_RESET;
			recip_census_q <= RECIP_CENSUS_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_RECIP_AD:     recip_ad_q     <= pwdata[RECIP_W-1:0];
				REG_RECIP_CENSUS: recip_census_q <= pwdata[RECIP_W-1:0];
				default:          ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_RECIP_AD:     prdata = PDATA_W'(recip_ad_q);
			REG_RECIP_CENSUS: prdata = PDATA_W'(recip_census_q);
			default:          prdata = '0;
		endcase
	end

	// Split the word into channels, red in lane 0
	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			left_pix[c]  = s_tdata[c*PIX_W +: PIX_W];
			right_pix[c] = s_tdata[(NUM_CH+c)*PIX_W +: PIX_W];
		end
	end

	// Channel lanes
	for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
		adcm_lane u_lane (
			.left_pix  (left_pix[c]),
			.right_pix (right_pix[c]),
			.left_ctr  (left_ctr_q[c]),
			.right_ctr (right_ctr_q[c]),
			.res       (lane_res[c])
		);
	end

	// Merge lane results: saturating census count and center difference sum
	always_comb begin
		mis_n = {1'b0, lane_res[0].mismatch} + {1'b0, lane_res[1].mismatch}
			+ {1'b0, lane_res[2].mismatch};
		cnt_sum  = {1'b0, census_q} + (CNT_W+1)'(mis_n);
		cnt_next = (cnt_sum > (CNT_W+1)'(CENSUS_LIMIT)) ? CNT_W'(CENSUS_LIMIT)
			: cnt_sum[CNT_W-1:0];
		ad_next = AD_W'(lane_res[0].abs_diff) + AD_W'(lane_res[1].abs_diff)
			+ AD_W'(lane_res[2].abs_diff);
	end

	assign s_tready = !v_s1 || cost_ready;
	assign accept   = s_tvalid && s_tready;

	// Window state: centers, difference sum, census count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CH; c++) begin
				left_ctr_q[c]  <= '0;
				right_ctr_q[c] <= '0;
			end
			ad_sum_q <= '0;
			census_q <= '0;
		end else if (accept) begin
			if (s_tuser == CMD_CENTER) begin
				left_ctr_q  <= left_pix;
				right_ctr_q <= right_pix;
				ad_sum_q    <= ad_next;
				census_q    <= '0;
			end else begin
				census_q <= cnt_next;
			end
		end
	end

	// Merge register: hold a result request until the cost stage takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept && s_tuser == CMD_WINDOW && s_tlast) begin
			v_s1 <= 1'b1;
		end else if (cost_ready) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && s_tuser == CMD_WINDOW && s_tlast) begin
			req_s1.ad_sum       <= ad_sum_q;
			req_s1.census_count <= cnt_next;
		end
	end

	adcm_cost u_cost (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (v_s1),
		.req          (req_s1),
		.req_ready    (cost_ready),
		.recip_ad     (recip_ad_q),
		.recip_census (recip_census_q),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata)
	);

endmodule

FILE: rtl/adcm_checker.sv
// Port-level checks for the AD-census matching cost block and their bind.
module adcm_checker import adcm_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic                  psel,
	input logic                  penable,
	input logic                  pwrite,
	input logic [PADDR_W-1:0]    paddr,
	input logic [PDATA_W-1:0]    pwdata,
	input logic [PDATA_W-1:0]    prdata,
	input logic                  pready
);

	// Hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// Drop input ready only when the output side backs up
	a_ready_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output backpressure");

	// Read back a register just written
	a_cfg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready |=>
		(paddr[2] != $past(paddr[2])) ||
		(prdata == PDATA_W'($past(pwdata[RECIP_W-1:0]))))
		else $error("register readback mismatch");

	// Keep result fields inside their ranges
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[32:25] <= CNT_W'(CENSUS_LIMIT)) &&
		(m_tdata[24:15] <= AD_W'(765)))
		else $error("result field out of range");

endmodule

bind ad_census_matching_cost adcm_checker u_adcm_checker (.*);

FILE: test/tb_top.sv
// Self-checking testbench for the AD-census matching cost block: directed and random stream traffic and APB setup.
module tb_top;
	import adcm_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES   = 8;
	localparam int NUM_PHASES     = 9;
	localparam logic [PADDR_W-1:0] ADDR_RECIP_AD     = 3'd0;
	localparam logic [PADDR_W-1:0] ADDR_RECIP_CENSUS = 3'd4;

	// exp(-2^b/16) in Q0.32 for the eight index bits of the lookup
	localparam logic [63:0] EXP_STEP_Q32 [8] = '{
		64'd4034748382, 64'd3790295335, 64'd3344923893, 64'd2605029348,
		64'd1580030169, 64'd581260616,  64'd78665070,   64'd1440801
	};

	// One input word; index 0 of each pixel is red
	typedef struct packed {
		logic            cmd;
		logic            last;
		logic [2:0][7:0] lpx;
		logic [2:0][7:0] rpx;
	} pix_word_t;

	typedef struct packed {
		logic [TOTAL_W-1:0] total;
		logic [AD_W-1:0]    ad;
		logic [CNT_W-1:0]   census;
	} cost_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	// left_red, left_green, left_blue, right_red, right_green, right_blue
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	// cmd
	logic                  s_tuser = 1'b0;
	logic                  s_tlast = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// total_cost, ad_sum, census_count, zero fill
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [PADDR_W-1:0]    paddr = '0;
	logic [PDATA_W-1:0]    pwdata = '0;
	logic [PDATA_W-1:0]    prdata;
	logic                  pready;

	// Predicted block state and register copies
	logic [2:0][7:0]    ctr_left = '0;
	logic [2:0][7:0]    ctr_right = '0;
	int unsigned        ad_acc = 0;
	int unsigned        census_acc = 0;
	logic [RECIP_W-1:0] ad_recip = RECIP_AD_RESET;
	logic [RECIP_W-1:0] census_recip = RECIP_CENSUS_RESET;

	pix_word_t pending_words [$];
	cost_t     cost_due [$];
	pix_word_t held_word;
	bit        word_held = 0;
	int        send_wait = 0;
	int        send_quiet = 0;
	int        recv_wait = 0;
	int        recv_quiet = 0;
	int        fail_cnt = 0;
	int        idle_cycles = 0;
	cost_t     got_cost;
	cost_t     want_cost;

	ad_census_matching_cost u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #1 clk = ~clk;

	// exp(-idx/16) in Q0.14 from rounded Q0.32 partial products
	function automatic int unsigned exp_q14(input int unsigned idx);
		logic [63:0] acc;
		acc = 64'd1 << 32;
		for (int b = 0; b < 8; b++) begin
			if (idx[b]) begin
				acc = (acc * EXP_STEP_Q32[b] + (64'd1 << 31)) >> 32;
			end
		end
		return int'((acc + (64'd1 << 17)) >> 18);
	endfunction

	// Clamp the Q4.4 argument to the table and look it up
	function automatic int unsigned exp_of_count(input int unsigned cnt,
			input logic [RECIP_W-1:0] recip);
		int unsigned arg;
		arg = (cnt * recip) >> ARG_SHIFT;
		if (arg > EXP_TABLE_DEPTH - 1) begin
			arg = EXP_TABLE_DEPTH - 1;
		end
		return exp_q14(arg);
	endfunction

	// Advance the predicted state by one accepted word, queue the cost it yields
	function automatic void predict_cost(input pix_word_t w);
		cost_t       c;
		int unsigned total;
		bit          opposite;
		if (w.cmd == CMD_CENTER) begin
			ctr_left  = w.lpx;
			ctr_right = w.rpx;
			ad_acc    = 0;
			for (int ch = 0; ch < NUM_CH; ch++) begin
				ad_acc += (w.lpx[ch] > w.rpx[ch]) ? w.lpx[ch] - w.rpx[ch] : w.rpx[ch] - w.lpx[ch];
			end
			census_acc = 0;
		end else begin
			for (int ch = 0; ch < NUM_CH; ch++) begin
				opposite = (w.lpx[ch] < ctr_left[ch] && w.rpx[ch] > ctr_right[ch]) ||
					(w.lpx[ch] > ctr_left[ch] && w.rpx[ch] < ctr_right[ch]);
				if (opposite && census_acc < CENSUS_LIMIT) begin
					census_acc++;
				end
			end
			if (w.last) begin
				total = 32768 - exp_of_count(ad_acc, ad_recip) -
					exp_of_count(census_acc, census_recip);
				if (total > 32767) begin
					total = 32767;
				end
				c.total  = total[TOTAL_W-1:0];
				c.ad     = ad_acc[AD_W-1:0];
				c.census = census_acc[CNT_W-1:0];
				cost_due.push_back(c);
			end
		end
	endfunction

	function automatic void note_fail(input string msg);
		fail_cnt++;
		if (fail_cnt <= 10) begin
			$display("%s", msg);
		end
	endfunction

	function automatic void add_word(input logic cmd, input logic last,
			input logic [2:0][7:0] lpx, input logic [2:0][7:0] rpx);
		pix_word_t w;
		w.cmd  = cmd;
		w.last = last;
		w.lpx  = lpx;
		w.rpx  = rpx;
		pending_words.push_back(w);
	endfunction

	// Sample close to a center so that census compares land on all three outcomes
	function automatic logic [7:0] near_value(input logic [7:0] c);
		int v;
		case ($urandom_range(3, 0))
			0: begin
				v = int'(c);
			end
			1: begin
				v = $urandom_range(255, 0);
			end
			default: begin
				v = int'(c) + int'($urandom_range(4, 0)) - 2;
			end
		endcase
		if (v < 0) begin
			v = 0;
		end
		if (v > 255) begin
			v = 255;
		end
		return v[7:0];
	endfunction

	// Hold until the stream is drained and the pipeline has settled
	task automatic wait_idle();
		while (pending_words.size() != 0 || word_held || cost_due.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// APB write: setup cycle, then access cycle; the register takes it on the last edge
	task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [RECIP_W-1:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= PDATA_W'(val);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (addr)
			ADDR_RECIP_AD: begin
				ad_recip = val;
			end
			ADDR_RECIP_CENSUS: begin
				census_recip = val;
			end
			default: begin
			end
		endcase
	endtask

	// Stream driver: present one word, hold it until taken, then idle a drawn number of cycles
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= 1'b0;
			s_tlast  <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_cost(held_word);
				word_held = 0;
				if (send_quiet > 0) begin
					send_quiet--;
					send_wait = 0;
				end else begin
					if ($urandom_range(15, 0) == 0) begin
						send_quiet = $urandom_range(40, 10);
					end
					send_wait = $urandom_range(14, 0);
				end
			end
			if (!word_held && send_wait > 0) begin
				send_wait--;
			end else if (!word_held && pending_words.size() != 0) begin
				held_word = pending_words.pop_front();
				word_held = 1;
				s_tdata <= {held_word.rpx, held_word.lpx};
				s_tuser <= held_word.cmd;
				s_tlast <= held_word.last;
			end
			s_tvalid <= word_held;
		end
	end

	// Result monitor: check each cost word against the oldest prediction, stall at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_cost.total  = m_tdata[TOTAL_W-1:0];
				got_cost.ad     = m_tdata[TOTAL_W+AD_W-1:TOTAL_W];
				got_cost.census = m_tdata[TOTAL_W+AD_W+CNT_W-1:TOTAL_W+AD_W];
				if (cost_due.size() == 0) begin
					note_fail($sformatf("unexpected cost word: total %0d ad %0d census %0d",
						got_cost.total, got_cost.ad, got_cost.census));
				end else begin
					want_cost = cost_due.pop_front();
					if (got_cost.total != want_cost.total || got_cost.ad != want_cost.ad ||
							got_cost.census != want_cost.census) begin
						note_fail($sformatf(
							"cost mismatch: got total %0d ad %0d census %0d, want %0d %0d %0d",
							got_cost.total, got_cost.ad, got_cost.census,
							want_cost.total, want_cost.ad, want_cost.census));
					end
				end
				if (recv_quiet > 0) begin
					recv_quiet--;
					recv_wait = 0;
				end else begin
					if ($urandom_range(15, 0) == 0) begin
						recv_quiet = $urandom_range(40, 10);
					end
					recv_wait = $urandom_range(14, 0);
				end
			end
			if (recv_wait > 0) begin
				recv_wait--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Watchdog: stop the run when neither side moves a word for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		logic [2:0][7:0]    lc;
		logic [2:0][7:0]    rc;
		logic [2:0][7:0]    lw;
		logic [2:0][7:0]    rw;
		logic [RECIP_W-1:0] ad_r;
		logic [RECIP_W-1:0] cen_r;
		int                 run_len;
		int                 queued;
		bit                 hot;
		bit                 dir;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed words with the reset register values
		// window against the cleared centers before any load
		add_word(CMD_WINDOW, 1'b1, 24'h123456, 24'hFEDCBA);
		// center load carrying the last flag: no cost word
		add_word(CMD_CENTER, 1'b1, 24'h8000FF, 24'h80FF00);
		add_word(CMD_WINDOW, 1'b0, 24'hC8FF00, 24'h6400FF);
		add_word(CMD_WINDOW, 1'b1, 24'h8000FF, 24'h80FF00);
		// second last without a reload keeps the count
		add_word(CMD_WINDOW, 1'b1, 24'h8001FE, 24'h80FE01);
		add_word(CMD_CENTER, 1'b0, 24'hFFFFFF, 24'h000000);
		add_word(CMD_WINDOW, 1'b1, 24'h000000, 24'h000000);
		add_word(CMD_CENTER, 1'b0, 24'h000000, 24'h000000);
		add_word(CMD_WINDOW, 1'b1, 24'hFFFFFF, 24'hFFFFFF);
		add_word(CMD_CENTER, 1'b0, 24'h808080, 24'h808080);
		add_word(CMD_WINDOW, 1'b0, 24'h7F7F7F, 24'h818181);
		add_word(CMD_WINDOW, 1'b0, 24'h808080, 24'h808080);
		add_word(CMD_WINDOW, 1'b1, 24'h818181, 24'h7F7F7F);
		add_word(CMD_WINDOW, 1'b1, 24'h808080, 24'h000000);

		// Random phases, each under its own register setting
		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_idle();
			case (p)
				0: begin
					ad_r  = RECIP_AD_RESET;
					cen_r = RECIP_CENSUS_RESET;
				end
				1: begin
					ad_r  = '0;
					cen_r = '0;
				end
				2: begin
					ad_r  = '1;
					cen_r = '1;
				end
				3: begin
					ad_r  = '0;
					cen_r = '1;
				end
				4: begin
					ad_r  = '1;
					cen_r = '0;
				end
				5: begin
					ad_r  = 16'd1;
					cen_r = 16'd1;
				end
				default: begin
					ad_r  = 16'($urandom_range(65535, 0));
					cen_r = 16'($urandom_range(65535, 0));
				end
			endcase
			reg_write(ADDR_RECIP_AD, ad_r);
			reg_write(ADDR_RECIP_CENSUS, cen_r);

			queued = 0;
			while (queued < 36) begin
				if ($urandom_range(6, 0) == 0) begin
					// stray word of any kind
					lw = 24'($urandom);
					rw = 24'($urandom);
					add_word(1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)), lw, rw);
					queued++;
				end else begin
					// center load, then a window ending in last
					hot     = ($urandom_range(3, 0) == 0);
					run_len = ($urandom_range(11, 0) == 0) ? $urandom_range(80, 60)
						: $urandom_range(8, 1);
					for (int ch = 0; ch < NUM_CH; ch++) begin
						lc[ch] = 8'(hot ? $urandom_range(254, 1) : $urandom_range(255, 0));
						rc[ch] = 8'(hot ? $urandom_range(254, 1) : $urandom_range(255, 0));
					end
					add_word(CMD_CENTER, 1'($urandom_range(1, 0)), lc, rc);
					for (int k = 0; k < run_len; k++) begin
						for (int ch = 0; ch < NUM_CH; ch++) begin
							if (hot) begin
								dir    = 1'($urandom_range(1, 0));
								lw[ch] = 8'(dir ? $urandom_range(255, lc[ch] + 1)
									: $urandom_range(lc[ch] - 1, 0));
								rw[ch] = 8'(dir ? $urandom_range(rc[ch] - 1, 0)
									: $urandom_range(255, rc[ch] + 1));
							end else begin
								lw[ch] = near_value(lc[ch]);
								rw[ch] = near_value(rc[ch]);
							end
						end
						add_word(CMD_WINDOW, k == run_len - 1, lw, rw);
					end
					queued += run_len + 1;
				end
			end
		end

		wait_idle();
		if (fail_cnt == 0 && cost_due.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
